// ===== src/vfts_pkg.sv =====
// ----------------------------------------------------------------------------
// vfts_pkg
// shared widths, types and defaults of the value frequency table with sorted
// readout
// ----------------------------------------------------------------------------
package vfts_pkg;

  localparam int SCORE_W         = 16;
  localparam int COUNT_W         = 16;
  localparam int RANK_W          = 4;
  localparam int TABLE_DEPTH_DEF = 16;

  typedef logic signed [SCORE_W-1:0] score_t;
  typedef logic        [COUNT_W-1:0] count_t;
  typedef logic        [RANK_W-1:0]  rank_t;

  localparam count_t COUNT_MAX = '1;

endpackage

// ===== src/vfts_if.sv =====
// ----------------------------------------------------------------------------
// vfts channel interfaces
// valid/ready channels for the score input and the sorted entry output
// ----------------------------------------------------------------------------
interface vfts_in_if;
  logic            valid;
  logic            ready;
  vfts_pkg::score_t score;
  logic            final_score;

  modport source (output valid, output score, output final_score, input ready);
  modport sink   (input valid, input score, input final_score, output ready);
endinterface

interface vfts_out_if;
  logic             valid;
  logic             ready;
  vfts_pkg::score_t entry_value;
  vfts_pkg::count_t entry_count;
  vfts_pkg::rank_t  entry_rank;
  logic             final_entry;
  logic             values_dropped;

  modport source (output valid, output entry_value, output entry_count,
                  output entry_rank, output final_entry, output values_dropped,
                  input ready);
  modport sink   (input valid, input entry_value, input entry_count,
                  input entry_rank, input final_entry, input values_dropped,
                  output ready);
endinterface

// ===== src/value_frequency_table_sort_top.sv =====
// ----------------------------------------------------------------------------
// value_frequency_table_sort_top
// counts distinct scores in a table kept in order of first appearance; on the
// last score of a batch it sorts by descending count and streams the table out
// ----------------------------------------------------------------------------
//  channel | dir | payload                                            | rule
//  in_if   | in  | score, final_score                                 | valid & ready
//  out_if  | out | entry_value, entry_count, entry_rank, final_entry, | valid & ready
//          |     | values_dropped                                     |
//
//  a score is appended straight away on an empty table, else it is compared
//  against the entries in turn (up to TABLE_DEPTH), one table read per cycle
//  through the single read port of the table memory
//  a final score adds the exchange sort: a load state, then per rank n a fetch,
//  a scan over the entries after n and an output state that holds while stalled
//  synchronous active-low reset clears the state, the entry count and the drop
//  flag; no clearing pass, table entries are only used below the entry count
//  in_if.ready is low from the acceptance of a score until its work is done;
//  an output stall simply holds the current entry
// ----------------------------------------------------------------------------
module value_frequency_table_sort_top #(
  parameter int TABLE_DEPTH = vfts_pkg::TABLE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  vfts_in_if.sink          in_if,
  vfts_out_if.source       out_if
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SEARCH = 3'd1;
  localparam logic [2:0] ST_LOAD   = 3'd2;
  localparam logic [2:0] ST_FETCH  = 3'd3;
  localparam logic [2:0] ST_SCAN   = 3'd4;
  localparam logic [2:0] ST_EMIT   = 3'd5;

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  // table memory
  vfts_pkg::score_t val_mem [TABLE_DEPTH];
  vfts_pkg::count_t cnt_mem [TABLE_DEPTH];

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] used_r, used_nxt;
  logic             drop_r, drop_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [CNT_W-1:0] o_r, o_nxt;
  vfts_pkg::score_t score_r, score_nxt;
  logic             final_r, final_nxt;
  vfts_pkg::score_t cur_val_r, cur_val_nxt;
  vfts_pkg::count_t cur_cnt_r, cur_cnt_nxt;
  vfts_pkg::score_t rd_val_r;
  vfts_pkg::count_t rd_cnt_r;

  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  vfts_pkg::score_t mem_wval;
  vfts_pkg::count_t mem_wcnt;
  logic [IDX_W-1:0] rd_addr;

  logic             in_acc;
  logic             out_acc;
  logic             cmp_last;
  logic [CNT_W-1:0] o_inc;
  logic [CNT_W-1:0] n_inc;

  assign in_acc   = in_if.valid && in_if.ready;
  assign out_acc  = out_if.valid && out_if.ready;
  assign cmp_last = (CNT_W'(cmp_idx_r) + 1'b1) == used_r;
  assign o_inc    = o_r + 1'b1;
  assign n_inc    = n_r + 1'b1;

  assign in_if.ready           = (state_r == ST_IDLE);
  assign out_if.valid          = (state_r == ST_EMIT);
  assign out_if.entry_value    = cur_val_r;
  assign out_if.entry_count    = cur_cnt_r;
  assign out_if.entry_rank     = vfts_pkg::RANK_W'(n_r);
  assign out_if.final_entry    = (n_inc == used_r);
  assign out_if.values_dropped = drop_r;

  always_comb begin
    state_nxt   = state_r;
    used_nxt    = used_r;
    drop_nxt    = drop_r;
    cmp_idx_nxt = cmp_idx_r;
    n_nxt       = n_r;
    o_nxt       = o_r;
    score_nxt   = score_r;
    final_nxt   = final_r;
    cur_val_nxt = cur_val_r;
    cur_cnt_nxt = cur_cnt_r;
    mem_we      = 1'b0;
    mem_wa      = '0;
    mem_wval    = score_r;
    mem_wcnt    = 16'd1;
    rd_addr     = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          score_nxt   = in_if.score;
          final_nxt   = in_if.final_score;
          cmp_idx_nxt = '0;
          n_nxt       = '0;
          if (used_r == '0) begin
            // empty table: append straight away
            mem_we    = 1'b1;
            mem_wa    = '0;
            mem_wval  = in_if.score;
            used_nxt  = CNT_W'(1);
            state_nxt = in_if.final_score ? ST_LOAD : ST_IDLE;
          end else begin
            state_nxt = ST_SEARCH;
          end
        end
      end

      ST_SEARCH: begin
        // read data holds the entry at cmp_idx_r
        rd_addr = cmp_idx_r + 1'b1;
        if (rd_val_r == score_r) begin
          mem_we    = 1'b1;
          mem_wa    = cmp_idx_r;
          mem_wval  = rd_val_r;
          mem_wcnt  = (rd_cnt_r == vfts_pkg::COUNT_MAX) ? rd_cnt_r : rd_cnt_r + 1'b1;
          state_nxt = final_r ? ST_LOAD : ST_IDLE;
        end else if (cmp_last) begin
          if (used_r < DEPTH_C) begin
            mem_we   = 1'b1;
            mem_wa   = used_r[IDX_W-1:0];
            used_nxt = used_r + 1'b1;
          end else begin
            drop_nxt = 1'b1;
          end
          state_nxt = final_r ? ST_LOAD : ST_IDLE;
        end else begin
          cmp_idx_nxt = cmp_idx_r + 1'b1;
        end
      end

      ST_LOAD: begin
        rd_addr   = n_r[IDX_W-1:0];
        state_nxt = ST_FETCH;
      end

      ST_FETCH: begin
        // entry n becomes the running candidate for rank n
        cur_val_nxt = rd_val_r;
        cur_cnt_nxt = rd_cnt_r;
        o_nxt       = n_inc;
        rd_addr     = n_inc[IDX_W-1:0];
        state_nxt   = (n_inc == used_r) ? ST_EMIT : ST_SCAN;
      end

      ST_SCAN: begin
        rd_addr = o_inc[IDX_W-1:0];
        if (rd_cnt_r > cur_cnt_r) begin
          // swap: old candidate goes to slot o
          mem_we      = 1'b1;
          mem_wa      = o_r[IDX_W-1:0];
          mem_wval    = cur_val_r;
          mem_wcnt    = cur_cnt_r;
          cur_val_nxt = rd_val_r;
          cur_cnt_nxt = rd_cnt_r;
        end
        o_nxt = o_inc;
        if (o_inc == used_r) begin
          state_nxt = ST_EMIT;
        end
      end

      ST_EMIT: begin
        rd_addr = n_inc[IDX_W-1:0];
        if (out_acc) begin
          if (n_inc == used_r) begin
            used_nxt  = '0;
            drop_nxt  = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            n_nxt     = n_inc;
            state_nxt = ST_FETCH;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      used_r  <= '0;
      drop_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      drop_r  <= drop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= cmp_idx_nxt;
    n_r       <= n_nxt;
    o_r       <= o_nxt;
    score_r   <= score_nxt;
    final_r   <= final_nxt;
    cur_val_r <= cur_val_nxt;
    cur_cnt_r <= cur_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      val_mem[mem_wa] <= mem_wval;
      cnt_mem[mem_wa] <= mem_wcnt;
    end
    rd_val_r <= val_mem[rd_addr];
    rd_cnt_r <= cnt_mem[rd_addr];
  end

endmodule

// ===== tb/vfts_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vfts_checker
// watches the score and entry channels, keeps its own value table, ranks it
// by count on every final score and checks each streamed entry against it
// ----------------------------------------------------------------------------
module vfts_checker #(
  parameter int TABLE_DEPTH = vfts_pkg::TABLE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  vfts_pkg::score_t in_score,
  input  logic             in_final_score,
  input  logic             out_valid,
  input  logic             out_ready,
  input  vfts_pkg::score_t out_entry_value,
  input  vfts_pkg::count_t out_entry_count,
  input  vfts_pkg::rank_t  out_entry_rank,
  input  logic             out_final_entry,
  input  logic             out_values_dropped,
  input  logic             end_check,
  output int               mismatch_count,
  output int               entries_pending,
  output int               scores_seen,
  output int               entries_seen,
  output int               batches_seen,
  output int               overflow_batches,
  output int               saturated_entries
);

  localparam int PRINT_CAP = 100;

  typedef struct {
    vfts_pkg::score_t value;
    vfts_pkg::count_t count;
    vfts_pkg::rank_t  rank;
    logic             tail;
    logic             dropped;
  } table_entry_t;

  vfts_pkg::score_t tbl_value [TABLE_DEPTH];
  vfts_pkg::count_t tbl_count [TABLE_DEPTH];
  int               used;
  bit               drop_seen;
  table_entry_t     sorted_entries_due [$];

  int  mismatches;
  int  n_scores;
  int  n_entries;
  int  n_batches;
  int  n_overflow;
  int  n_saturated;
  bit  end_done;

  task automatic report_mismatch(input string what);
    if (mismatches < PRINT_CAP)
      $display("[%0t] vfts mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // count one score into the table, appending on a miss while room is left
  task automatic tally_score(input vfts_pkg::score_t s);
    bit hit;
    hit = 1'b0;
    for (int i = 0; i < used; i++) begin
      if (!hit && tbl_value[i] == s) begin
        hit = 1'b1;
        if (tbl_count[i] != vfts_pkg::COUNT_MAX) tbl_count[i] = tbl_count[i] + 1'b1;
      end
    end
    if (!hit) begin
      if (used < TABLE_DEPTH) begin
        tbl_value[used] = s;
        tbl_count[used] = vfts_pkg::count_t'(1);
        used++;
      end else begin
        drop_seen = 1'b1;
      end
    end
  endtask

  // exchange sort by descending count, then queue the readout and start afresh
  task automatic rank_table();
    vfts_pkg::score_t v;
    vfts_pkg::count_t c;
    table_entry_t     e;
    for (int n = 0; n < used; n++) begin
      for (int o = n; o < used; o++) begin
        if (tbl_count[o] > tbl_count[n]) begin
          c = tbl_count[o]; tbl_count[o] = tbl_count[n]; tbl_count[n] = c;
          v = tbl_value[o]; tbl_value[o] = tbl_value[n]; tbl_value[n] = v;
        end
      end
    end
    for (int k = 0; k < used; k++) begin
      e.value   = tbl_value[k];
      e.count   = tbl_count[k];
      e.rank    = vfts_pkg::rank_t'(k);
      e.tail    = (k == used - 1);
      e.dropped = drop_seen;
      sorted_entries_due.push_back(e);
      if (tbl_count[k] == vfts_pkg::COUNT_MAX) n_saturated++;
    end
    n_batches++;
    if (drop_seen) n_overflow++;
    used      = 0;
    drop_seen = 1'b0;
  endtask

  task automatic check_entry();
    table_entry_t want;
    n_entries++;
    if (sorted_entries_due.size() == 0) begin
      report_mismatch($sformatf("entry with none pending: value %0d count %0d rank %0d",
                                out_entry_value, out_entry_count, out_entry_rank));
      return;
    end
    want = sorted_entries_due.pop_front();
    if (out_entry_value !== want.value)
      report_mismatch($sformatf("rank %0d value %0d, want %0d",
                                want.rank, out_entry_value, want.value));
    if (out_entry_count !== want.count)
      report_mismatch($sformatf("rank %0d count %0d, want %0d",
                                want.rank, out_entry_count, want.count));
    if (out_entry_rank !== want.rank)
      report_mismatch($sformatf("rank field %0d, want %0d", out_entry_rank, want.rank));
    if (out_final_entry !== want.tail)
      report_mismatch($sformatf("rank %0d final_entry %b, want %b",
                                want.rank, out_final_entry, want.tail));
    if (out_values_dropped !== want.dropped)
      report_mismatch($sformatf("rank %0d values_dropped %b, want %b",
                                want.rank, out_values_dropped, want.dropped));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      used      = 0;
      drop_seen = 1'b0;
      sorted_entries_due.delete();
      mismatches  = 0;
      n_scores    = 0;
      n_entries   = 0;
      n_batches   = 0;
      n_overflow  = 0;
      n_saturated = 0;
      end_done    = 1'b0;
    end else begin
      if (out_valid && out_ready) check_entry();
      if (in_valid && in_ready) begin
        n_scores++;
        tally_score(in_score);
        if (in_final_score) rank_table();
      end
      if (end_check && !end_done) begin
        end_done = 1'b1;
        foreach (sorted_entries_due[i])
          report_mismatch($sformatf("entry rank %0d value %0d never arrived",
                                    sorted_entries_due[i].rank,
                                    sorted_entries_due[i].value));
        sorted_entries_due.delete();
      end
    end
    mismatch_count    <= mismatches;
    entries_pending   <= sorted_entries_due.size();
    scores_seen       <= n_scores;
    entries_seen      <= n_entries;
    batches_seen      <= n_batches;
    overflow_batches  <= n_overflow;
    saturated_entries <= n_saturated;
  end

endmodule

// ===== tb/value_frequency_table_sort_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// value_frequency_table_sort_top_tb
// drives batches of scores with random gaps and result stalls: a few directed
// batches, one long run of a single value, then random batches, some of
// which overflow the table; the checker beside the block does the comparing
// ----------------------------------------------------------------------------
module value_frequency_table_sort_top_tb;

  localparam int DEPTH         = vfts_pkg::TABLE_DEPTH_DEF;
  localparam int RANDOM_SCORES = 440;
  localparam int RUN_LEN       = 40;
  localparam int TAIL_CYCLES   = 4 * DEPTH + 20;
  localparam int CYCLE_LIMIT   = 3_000_000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic end_check = 1'b0;

  vfts_in_if  in_if ();
  vfts_out_if out_if ();

  int mismatch_count;
  int entries_pending;
  int scores_seen;
  int entries_seen;
  int batches_seen;
  int overflow_batches;
  int saturated_entries;

  value_frequency_table_sort_top #(.TABLE_DEPTH(DEPTH)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  vfts_checker #(.TABLE_DEPTH(DEPTH)) u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_if.valid),
    .in_ready           (in_if.ready),
    .in_score           (in_if.score),
    .in_final_score     (in_if.final_score),
    .out_valid          (out_if.valid),
    .out_ready          (out_if.ready),
    .out_entry_value    (out_if.entry_value),
    .out_entry_count    (out_if.entry_count),
    .out_entry_rank     (out_if.entry_rank),
    .out_final_entry    (out_if.final_entry),
    .out_values_dropped (out_if.values_dropped),
    .end_check          (end_check),
    .mismatch_count     (mismatch_count),
    .entries_pending    (entries_pending),
    .scores_seen        (scores_seen),
    .entries_seen       (entries_seen),
    .batches_seen       (batches_seen),
    .overflow_batches   (overflow_batches),
    .saturated_entries  (saturated_entries)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    in_if.valid       = 1'b0;
    in_if.score       = '0;
    in_if.final_score = 1'b0;
    out_if.ready      = 1'b0;
  end

  int cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("value_frequency_table_sort_top_tb NOT OK");
      $finish;
    end
  end

  // result side: random stalls, mostly short, unless held steady
  bit sink_steady = 1'b0;
  int stall_left  = 0;
  always @(posedge clk) begin
    int r;
    r = $urandom_range(99);
    if (sink_steady) begin
      out_if.ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left--;
    end else if (r < 60) begin
      out_if.ready <= 1'b1;
    end else if (r < 92) begin
      out_if.ready <= 1'b0;
      stall_left = $urandom_range(2);
    end else begin
      out_if.ready <= 1'b0;
      stall_left = $urandom_range(40, 5);
    end
  end

  bit src_steady = 1'b0;

  function automatic int idle_cycles();
    int r;
    r = $urandom_range(99);
    if (src_steady || r < 55) return 0;
    if (r < 88) return $urandom_range(3, 1);
    return $urandom_range(30, 6);
  endfunction

  // called just after the clock rises; returns once the score is taken
  task automatic send_score(input vfts_pkg::score_t s, input logic last);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      in_if.score <= vfts_pkg::score_t'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.score       <= s;
    in_if.final_score <= last;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic wait_for_drain();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (entries_pending != 0);
  endtask

  vfts_pkg::score_t pool [64];
  int               random_sent;
  int               batch_len;
  int               n_distinct;
  int               r;

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single score batch at the negative extreme
    send_score(16'sh8000, 1'b1);

    // reordering by count
    send_score(16'sh7fff, 1'b0);
    send_score(16'sh0000, 1'b0);
    send_score(-16'sd1,   1'b0);
    send_score(16'sh0000, 1'b0);
    send_score(-16'sd1,   1'b0);
    send_score(-16'sd1,   1'b1);

    // fill the table, then drop new values, the final one too
    for (int i = 0; i < DEPTH; i++)
      send_score(vfts_pkg::score_t'(1 << (i % 16)) ^ vfts_pkg::score_t'(i), 1'b0);
    send_score(16'sh1234, 1'b0);
    send_score(vfts_pkg::score_t'(1 << 3) ^ vfts_pkg::score_t'(3), 1'b0);
    send_score(16'sh4321, 1'b1);
    wait_for_drain();

    // long run of one value behind an entry seen once
    src_steady = 1'b1;
    sink_steady <= 1'b1;
    send_score(16'sh7ffe, 1'b0);
    for (int i = 0; i < RUN_LEN; i++) send_score(-16'sd2, i == RUN_LEN - 1);
    src_steady = 1'b0;
    wait_for_drain();
    sink_steady <= 1'b0;

    random_sent = 0;
    while (random_sent < RANDOM_SCORES) begin
      r = $urandom_range(99);
      batch_len = (r < 70) ? $urandom_range(24, 1) :
                  (r < 90) ? $urandom_range(60, 25) : $urandom_range(3, 1);
      r = $urandom_range(99);
      n_distinct = (r < 70) ? $urandom_range(12, 1) :
                   (r < 90) ? $urandom_range(16, 13) : $urandom_range(40, 17);
      for (int i = 0; i < n_distinct; i++) begin
        case ($urandom_range(19))
          0:       pool[i] = 16'sh8000;
          1:       pool[i] = 16'sh7fff;
          2:       pool[i] = '0;
          3:       pool[i] = -16'sd1;
          default: pool[i] = vfts_pkg::score_t'($urandom);
        endcase
      end
      src_steady = ($urandom_range(3) == 0);
      sink_steady <= ($urandom_range(3) == 0);
      for (int i = 0; i < batch_len; i++)
        send_score(pool[$urandom_range(n_distinct - 1)], i == batch_len - 1);
      random_sent += batch_len;
      if ($urandom_range(4) == 0) wait_for_drain();
    end

    wait_for_drain();
    sink_steady <= 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk);
    end_check <= 1'b1;
    repeat (3) @(posedge clk);

    $display("covered %0d scores in %0d batches, %0d sorted entries checked",
             scores_seen, batches_seen, entries_seen);
    $display("%0d batches overflowed the table, %0d entries held a saturated count",
             overflow_batches, saturated_entries);
    if (mismatch_count == 0) begin
      $display("value_frequency_table_sort_top_tb OK");
    end else begin
      $display("value_frequency_table_sort_top_tb NOT OK");
    end
    $finish;
  end

endmodule
